FILE: rtl/sprite_row_rle_encoder_macros.svh
// Assertion macros shared by the sprite row encoder modules.
`ifndef SPRITE_ROW_RLE_ENCODER_MACROS_SVH
`define SPRITE_ROW_RLE_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SRLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sprite row encoder assertion failed");

`define SRLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite row encoder assertion failed");

`else

`define SRLE_ASSERT(lbl, clk, rst, prop)

`define SRLE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/srle_pkg.sv
// Types and constants shared by the sprite row encoder modules.
`timescale 1ns / 1ps

package srle_pkg;

  localparam int RUN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 3;

  localparam logic [BYTE_W-1:0] ROW_END_CODE = 8'h80;
  localparam logic [BYTE_W-1:0] SKIP_FLAG    = 8'h80;
  localparam logic [RUN_W-1:0]  RUN_LIMIT    = 7'h7f;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_HEAD,
    S_BODY,
    S_UPDATE,
    S_HEAD_EOL,
    S_BODY_EOL,
    S_ROW_END
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_HEAD,
    EMIT_BODY,
    EMIT_ROW_END
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  update;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic close_needed;
    logic run_transparent;
    logic next_transparent;
    logic body_last;
    logic eol;
    logic pack_empty;
  } status_t;

endpackage

FILE: rtl/srle_datapath.sv
// Run state, literal buffer, byte selection and word packing of the sprite row encoder.
`timescale 1ns / 1ps
`include "sprite_row_rle_encoder_macros.svh"

module srle_datapath #(
  parameter int MAX_RUN = 127
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [srle_pkg::BYTE_W-1:0]    in_pixel,
  input  logic                           in_eol,
  input  srle_pkg::cmd_t                 cmd,
  output srle_pkg::status_t              status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [srle_pkg::WORD_W-1:0]    out_word,
  output logic [srle_pkg::COUNT_W-1:0]   out_count,
  output logic                           out_last
);
  import srle_pkg::*;

  localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [RUN_W-1:0] MAX_LEN = RUN_W'(MAX_RUN);

  logic [BYTE_W-1:0] store [MAX_RUN];
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] pixel_r;
  logic              eol_r;
  logic              run_transparent;
  logic [RUN_W-1:0]  run_length;
  logic [RUN_W-1:0]  idx;
  logic [RUN_W-1:0]  idx_inc;
  logic [23:0]       acc;
  logic [1:0]        cnt;

  logic              pix_clear;
  logic              can_emit;
  logic              emitting;
  logic              body_last;
  logic              last_byte;
  logic              push;
  logic [BYTE_W-1:0] byte_val;
  logic [WORD_W-1:0] word;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign pix_clear = (pixel_r == '0);
  assign can_emit  = !out_valid || out_ready;
  assign emitting  = (cmd.emit != EMIT_NONE) && can_emit;
  assign body_last = (idx == run_length - RUN_W'(1));
  assign idx_inc   = idx + RUN_W'(1);

  always_comb begin
    unique case (cmd.emit)
      EMIT_HEAD: begin
        byte_val  = run_transparent ? (SKIP_FLAG | {1'b0, run_length}) : {1'b0, run_length};
        last_byte = run_transparent && !eol_r;
      end
      EMIT_BODY: begin
        byte_val  = rd_data;
        last_byte = body_last && !eol_r;
      end
      EMIT_ROW_END: begin
        byte_val  = ROW_END_CODE;
        last_byte = 1'b1;
      end
      default: begin
        byte_val  = '0;
        last_byte = 1'b0;
      end
    endcase
  end

  assign push = emitting && ((cnt == 2'd3) || last_byte);
  assign word = {8'h00, acc} | (WORD_W'(byte_val) << {cnt, 3'b000});

  assign rd_en   = emitting && (((cmd.emit == EMIT_HEAD) && !run_transparent) ||
                                ((cmd.emit == EMIT_BODY) && !body_last));
  assign rd_addr = (cmd.emit == EMIT_HEAD) ? '0 : idx_inc[ADDR_W-1:0];
  assign wr_en   = cmd.update && !pix_clear;
  assign wr_addr = run_length[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= pixel_r;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_r <= in_pixel;
      eol_r   <= in_eol;
    end
    if (emitting) begin
      if (cmd.emit == EMIT_HEAD) begin
        idx <= '0;
      end else if (cmd.emit == EMIT_BODY) begin
        idx <= idx_inc;
      end
    end
    if (push) begin
      out_word  <= word;
      out_count <= {1'b0, cnt} + COUNT_W'(1);
      out_last  <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_transparent <= 1'b0;
      run_length      <= '0;
      acc             <= '0;
      cnt             <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (run_length == '0) begin
          run_transparent <= pix_clear;
        end
        if (run_length != RUN_LIMIT) begin
          run_length <= run_length + RUN_W'(1);
        end
      end
      if (emitting) begin
        if (cmd.emit == EMIT_ROW_END) begin
          run_length <= '0;
        end else if ((cmd.emit == EMIT_HEAD) && run_transparent) begin
          run_length <= '0;
        end else if ((cmd.emit == EMIT_BODY) && body_last) begin
          run_length <= '0;
        end
        if (push) begin
          acc <= '0;
          cnt <= '0;
        end else begin
          acc <= word[23:0];
          cnt <= cnt + 2'd1;
        end
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.can_emit         = can_emit;
    status.close_needed     = (run_length != '0) &&
                              ((pix_clear != run_transparent) || (run_length >= MAX_LEN));
    status.run_transparent  = run_transparent;
    status.next_transparent = (run_length == '0) ? pix_clear : run_transparent;
    status.body_last        = body_last;
    status.eol              = eol_r;
    status.pack_empty       = (cnt == 2'd0);
  end

  `SRLE_ASSERT(a_count_range, clk, rst, out_valid |-> (out_count != 3'd0 && out_count <= 3'd4))
  `SRLE_ASSERT(a_body_in_run, clk, rst, (cmd.emit == EMIT_BODY) |-> (idx < run_length))
  `SRLE_ASSERT(a_run_bound, clk, rst, run_length <= MAX_LEN)
  `SRLE_ASSERT_NEXT(a_final_flush, clk, rst, push && last_byte, cnt == 2'd0)

endmodule

FILE: rtl/srle_ctrl.sv
// Sequencer of the sprite row encoder: orders run closing, pixel update and row end.
`timescale 1ns / 1ps
`include "sprite_row_rle_encoder_macros.svh"

module srle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srle_pkg::status_t status,
  output srle_pkg::cmd_t    cmd
);
  import srle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.update = 1'b0;
    cmd.emit   = EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = status.close_needed ? S_HEAD : S_UPDATE;
      end
      S_HEAD: begin
        cmd.emit = EMIT_HEAD;
        if (status.can_emit) begin
          state_next = status.run_transparent ? S_UPDATE : S_BODY;
        end
      end
      S_BODY: begin
        cmd.emit = EMIT_BODY;
        if (status.can_emit && status.body_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (!status.eol) begin
          state_next = S_IDLE;
        end else if (status.next_transparent) begin
          state_next = S_ROW_END;
        end else begin
          state_next = S_HEAD_EOL;
        end
      end
      S_HEAD_EOL: begin
        cmd.emit = EMIT_HEAD;
        if (status.can_emit) begin
          state_next = S_BODY_EOL;
        end
      end
      S_BODY_EOL: begin
        cmd.emit = EMIT_BODY;
        if (status.can_emit && status.body_last) begin
          state_next = S_ROW_END;
        end
      end
      S_ROW_END: begin
        cmd.emit = EMIT_ROW_END;
        if (status.can_emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SRLE_ASSERT(a_idle_flushed, clk, rst, (state == S_IDLE) |-> status.pack_empty)
  `SRLE_ASSERT(a_body_opaque, clk, rst, (state == S_BODY || state == S_BODY_EOL) |-> !status.run_transparent)
  `SRLE_ASSERT(a_row_end_eol, clk, rst, (state == S_ROW_END || state == S_HEAD_EOL) |-> status.eol)

endmodule

FILE: rtl/sprite_row_rle_encoder.sv
// Top level of the sprite row run-length encoder.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[7:0] pixel, s_tlast last_in_row
//   m_       out  m_tvalid/m_tready  m_tdata[31:0] data, [34:32] byte_count, m_tlast last
//
// A pixel that emits nothing passes the idle, decide and update states. Closing an
// opaque run emits a head and its pixels, a transparent run a head, the row end a code.
// The literal buffer gives one byte per cycle, output stalls apart, pacing an emission.
// Reset clears the run state and the packer; the literal buffer needs no clearing.
// While m_tready is low with a word held, byte emission stops and resumes in place.
`timescale 1ns / 1ps

module sprite_row_rle_encoder #(
  parameter int MAX_RUN = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] data, [34:32] byte_count, [39:35] zero
  output logic        m_tlast
);
  import srle_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [WORD_W-1:0]  out_word;
  logic [COUNT_W-1:0] out_count;

  srle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srle_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_pixel  (s_tdata),
    .in_eol    (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_word  (out_word),
    .out_count (out_count),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'b00000, out_count, out_word};

endmodule

FILE: verif/sprite_row_rle_encoder_test.sv
// Self-checking testbench for the sprite row run-length encoder.
`timescale 1ns / 1ps

module sprite_row_rle_encoder_test;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
  } pixel_word_t;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  byte_count;
    logic        last;
  } packed_word_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] pixel
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [31:0] data, [34:32] byte_count, [39:35] zero
  logic        m_tlast;

  pixel_word_t  pending_pixels[$];
  packed_word_t expected_words[$];
  logic [7:0]   emitted_bytes[$];

  logic         open_run_clear = 1'b0;
  int           open_run_len   = 0;
  logic [7:0]   run_pixels[0:126];

  int errors       = 0;
  int pixels_sent  = 0;
  int rows_sent    = 0;
  int words_seen   = 0;
  int full_closes  = 0;
  int random_count = 0;
  int send_gap     = 0;
  int ready_hold   = 0;
  bit burst_mode   = 1'b0;

  sprite_row_rle_encoder uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 59) == 0) burst_mode = ~burst_mode;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic void close_open_run(bit row_end);
    if (open_run_len == 0) return;
    if (open_run_clear) begin
      if (!row_end)
        emitted_bytes.push_back(srle_pkg::SKIP_FLAG | 8'(open_run_len));
    end else begin
      emitted_bytes.push_back(8'(open_run_len));
      for (int i = 0; i < open_run_len; i++)
        emitted_bytes.push_back(run_pixels[i]);
    end
    open_run_len = 0;
  endfunction

  function automatic void encode_pixel(logic [7:0] pixel, logic row_end);
    logic         clear;
    packed_word_t w;
    int           nbytes;
    clear = (pixel == 8'h00);
    emitted_bytes.delete();
    if (open_run_len != 0 &&
        (clear != open_run_clear || open_run_len >= int'(srle_pkg::RUN_LIMIT))) begin
      if (open_run_len >= int'(srle_pkg::RUN_LIMIT)) full_closes++;
      close_open_run(1'b0);
    end
    if (open_run_len == 0) open_run_clear = clear;
    if (!clear) run_pixels[open_run_len] = pixel;
    if (open_run_len < int'(srle_pkg::RUN_LIMIT)) open_run_len++;
    if (row_end) begin
      close_open_run(1'b1);
      emitted_bytes.push_back(srle_pkg::ROW_END_CODE);
    end
    nbytes = emitted_bytes.size();
    for (int pos = 0; pos < nbytes; pos += 4) begin
      w.data       = '0;
      w.byte_count = '0;
      for (int k = 0; k < 4 && pos + k < nbytes; k++) begin
        w.data[8*k +: 8] = emitted_bytes[pos + k];
        w.byte_count++;
      end
      w.last = (pos + 4 >= nbytes);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void push_pixel(logic [7:0] pixel, logic row_end);
    pixel_word_t p;
    p.pixel   = pixel;
    p.row_end = row_end;
    pending_pixels.push_back(p);
  endfunction

  function automatic void push_run(bit clear, int len, bit ends_row);
    for (int i = 0; i < len; i++)
      push_pixel(clear ? 8'h00 : 8'($urandom_range(1, 255)), ends_row && (i == len - 1));
  endfunction

  function automatic int pick_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 4);
    if (r < 94) return $urandom_range(5, 20);
    if (r < 97) return $urandom_range(125, 130);
    return $urandom_range(60, 260);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_pixel(s_tdata, s_tlast);
        pixels_sent++;
        if (s_tlast) rows_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_pixels[0].pixel;
          s_tlast  <= pending_pixels[0].row_end;
          void'(pending_pixels.pop_front());
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", m_tdata, 0);
        end else begin
          if (m_tdata[31:0] !== expected_words[0].data)
            report_mismatch("data", m_tdata[31:0], expected_words[0].data);
          if (m_tdata[34:32] !== expected_words[0].byte_count)
            report_mismatch("byte_count", m_tdata[34:32], expected_words[0].byte_count);
          if (m_tlast !== expected_words[0].last)
            report_mismatch("last", m_tlast, expected_words[0].last);
          if (m_tdata[39:35] !== 5'b0)
            report_mismatch("padding", m_tdata[39:35], 0);
          void'(expected_words.pop_front());
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        ready_hold = pick_gap();
      end
    end
  end

  initial begin
    // Single-pixel rows of both kinds.
    push_pixel(8'h05, 1'b1);
    push_pixel(8'h00, 1'b1);
    // Extreme pixel values, a transparent run closed by an opaque pixel.
    push_pixel(8'hff, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'h7f, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'haa, 1'b0);
    push_pixel(8'h55, 1'b1);
    // A transparent run that reaches the row end is dropped.
    push_pixel(8'h10, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h33, 1'b1);
    // Full runs: transparent at row end, opaque overflow, transparent overflow.
    push_run(1'b1, 127, 1'b1);
    push_run(1'b0, 128, 1'b1);
    push_run(1'b1, 128, 1'b0);
    push_pixel(8'h42, 1'b1);
    while (random_count < 40) begin
      int runs;
      int len;
      runs = $urandom_range(1, 6);
      for (int r = 0; r < runs; r++) begin
        len = pick_run_len();
        push_run($urandom_range(0, 99) < 40, len, r == runs - 1);
        random_count += len;
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_pixels.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Encoded %0d pixels in %0d rows into %0d checked words.",
             pixels_sent, rows_sent, words_seen);
    $display("Runs closed at the length limit: %0d; mismatches: %0d.", full_closes, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
